// ----- hw/rtl/rc4kc_pkg.sv -----
package rc4kc_pkg;

    localparam int unsigned MAX_KEY_LEN = 256;
    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned KEY_CNT_W   = 9;
    localparam int unsigned DROP_W      = 12;

    localparam logic [KEY_CNT_W-1:0] KEY_LIMIT  = KEY_CNT_W'(MAX_KEY_LEN);
    localparam logic [DROP_W-1:0]    DROP_RESET = DROP_W'(1024);
    localparam logic [7:0]           LAST_INDEX = 8'hff;

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_value;
        logic       last_flag;
    } req_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       result_last;
    } rsp_t;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } ram_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_WN,
        ST_KS_WJ,
        ST_PR_RI,
        ST_PR_RJ,
        ST_PR_WI,
        ST_PR_WJ,
        ST_PR_RT,
        ST_PR_OUT
    } state_t;

endpackage

// ----- hw/rtl/rc4kc_ram.sv -----
module rc4kc_ram (
    input  logic                clk,
    input  rc4kc_pkg::ram_req_t req,
    output logic [7:0]          rdata
);

    logic [7:0] mem [rc4kc_pkg::TABLE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rc4kc_seq.sv -----
module rc4kc_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  rc4kc_pkg::req_t                       req_data,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output rc4kc_pkg::rsp_t                       rsp_data,
    input  logic                                  drop_count_we,
    input  logic [rc4kc_pkg::DROP_W-1:0]          drop_count,
    output rc4kc_pkg::ram_req_t                   s_req,
    input  logic [7:0]                            s_rdata,
    output rc4kc_pkg::ram_req_t                   k_req,
    input  logic [7:0]                            k_rdata
);

    rc4kc_pkg::state_t state_reg, state_next;

    logic [7:0]                         i_reg, i_next;
    logic [7:0]                         j_reg, j_next;
    logic [7:0]                         a_reg, a_next;
    logic [7:0]                         b_reg, b_next;
    logic [7:0]                         k_reg, k_next;
    logic [rc4kc_pkg::KEY_CNT_W-1:0]    len_reg, len_next;
    logic [rc4kc_pkg::KEY_CNT_W-1:0]    key_count_reg, key_count_next;
    logic [rc4kc_pkg::DROP_W-1:0]       drop_count_reg, drop_count_next;
    logic [rc4kc_pkg::DROP_W-1:0]       drop_left_reg, drop_left_next;
    logic                               dropping_reg, dropping_next;
    logic [7:0]                         byte_reg, byte_next;
    logic                               last_reg, last_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    rc4kc_pkg::rsp_t                    rsp_data_reg, rsp_data_next;

    logic [7:0]                         add_x, add_y, add_z, add_sum;
    logic [rc4kc_pkg::KEY_CNT_W-1:0]    key_count_inc;
    logic [rc4kc_pkg::KEY_CNT_W-1:0]    k_inc;
    logic                               accept;
    logic                               out_free;

    assign add_sum  = add_x + add_y + add_z;
    assign accept   = req_valid && (state_reg == rc4kc_pkg::ST_IDLE);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign key_count_inc = key_count_reg + rc4kc_pkg::KEY_CNT_W'(1);
    assign k_inc         = {1'b0, k_reg} + rc4kc_pkg::KEY_CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rc4kc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_data.req_type == rc4kc_pkg::REQ_DATA)
                    begin
                        state_next = rc4kc_pkg::ST_PR_RI;
                    end
                    else if (req_data.last_flag)
                    begin
                        state_next = rc4kc_pkg::ST_FILL;
                    end
                end
            end
            rc4kc_pkg::ST_FILL:
            begin
                if (i_reg == rc4kc_pkg::LAST_INDEX)
                begin
                    state_next = rc4kc_pkg::ST_KS_RD;
                end
            end
            rc4kc_pkg::ST_KS_RD: state_next = rc4kc_pkg::ST_KS_J;
            rc4kc_pkg::ST_KS_J:  state_next = rc4kc_pkg::ST_KS_WN;
            rc4kc_pkg::ST_KS_WN: state_next = rc4kc_pkg::ST_KS_WJ;
            rc4kc_pkg::ST_KS_WJ:
            begin
                if (i_reg != rc4kc_pkg::LAST_INDEX)
                begin
                    state_next = rc4kc_pkg::ST_KS_RD;
                end
                else if (drop_count_reg == '0)
                begin
                    state_next = rc4kc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4kc_pkg::ST_PR_RI;
                end
            end
            rc4kc_pkg::ST_PR_RI: state_next = rc4kc_pkg::ST_PR_RJ;
            rc4kc_pkg::ST_PR_RJ: state_next = rc4kc_pkg::ST_PR_WI;
            rc4kc_pkg::ST_PR_WI: state_next = rc4kc_pkg::ST_PR_WJ;
            rc4kc_pkg::ST_PR_WJ:
            begin
                if (!dropping_reg)
                begin
                    state_next = rc4kc_pkg::ST_PR_RT;
                end
                else if (drop_left_reg == rc4kc_pkg::DROP_W'(1))
                begin
                    state_next = rc4kc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4kc_pkg::ST_PR_RI;
                end
            end
            rc4kc_pkg::ST_PR_RT: state_next = rc4kc_pkg::ST_PR_OUT;
            rc4kc_pkg::ST_PR_OUT:
            begin
                if (out_free)
                begin
                    state_next = rc4kc_pkg::ST_IDLE;
                end
            end
            default: state_next = rc4kc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        i_next          = i_reg;
        j_next          = j_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        k_next          = k_reg;
        len_next        = len_reg;
        key_count_next  = key_count_reg;
        drop_left_next  = drop_left_reg;
        dropping_next   = dropping_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        drop_count_next = drop_count_we ? drop_count : drop_count_reg;
        s_req           = '0;
        k_req           = '0;
        add_x           = '0;
        add_y           = '0;
        add_z           = '0;
        req_ready       = (state_reg == rc4kc_pkg::ST_IDLE);

        unique case (state_reg)
            rc4kc_pkg::ST_IDLE:
            begin
                if (accept && req_data.req_type == rc4kc_pkg::REQ_KEY)
                begin
                    if (key_count_reg < rc4kc_pkg::KEY_LIMIT)
                    begin
                        k_req.we       = 1'b1;
                        k_req.waddr    = key_count_reg[7:0];
                        k_req.wdata    = req_data.byte_value;
                        key_count_next = key_count_inc;
                    end
                    if (req_data.last_flag)
                    begin
                        len_next       = (key_count_reg < rc4kc_pkg::KEY_LIMIT) ?
                                         key_count_inc : key_count_reg;
                        key_count_next = '0;
                        i_next         = '0;
                        j_next         = '0;
                        k_next         = '0;
                    end
                end
                else if (accept)
                begin
                    byte_next     = req_data.byte_value;
                    last_next     = req_data.last_flag;
                    dropping_next = 1'b0;
                end
            end
            rc4kc_pkg::ST_FILL:
            begin
                s_req.we    = 1'b1;
                s_req.waddr = i_reg;
                s_req.wdata = i_reg;
                i_next      = i_reg + 8'd1;
            end
            rc4kc_pkg::ST_KS_RD:
            begin
                s_req.raddr = i_reg;
                k_req.raddr = k_reg;
            end
            rc4kc_pkg::ST_KS_J:
            begin
                add_x       = j_reg;
                add_y       = s_rdata;
                add_z       = k_rdata;
                j_next      = add_sum;
                a_next      = s_rdata;
                s_req.raddr = add_sum;
            end
            rc4kc_pkg::ST_KS_WN:
            begin
                s_req.we    = 1'b1;
                s_req.waddr = i_reg;
                s_req.wdata = s_rdata;
            end
            rc4kc_pkg::ST_KS_WJ:
            begin
                s_req.we    = 1'b1;
                s_req.waddr = j_reg;
                s_req.wdata = a_reg;
                i_next      = i_reg + 8'd1;
                k_next      = (k_inc >= len_reg) ? 8'd0 : k_inc[7:0];
                if (i_reg == rc4kc_pkg::LAST_INDEX)
                begin
                    j_next         = '0;
                    drop_left_next = drop_count_reg;
                    dropping_next  = 1'b1;
                end
            end
            rc4kc_pkg::ST_PR_RI:
            begin
                add_x       = i_reg;
                add_y       = 8'd1;
                i_next      = add_sum;
                s_req.raddr = add_sum;
            end
            rc4kc_pkg::ST_PR_RJ:
            begin
                add_x       = j_reg;
                add_y       = s_rdata;
                j_next      = add_sum;
                a_next      = s_rdata;
                s_req.raddr = add_sum;
            end
            rc4kc_pkg::ST_PR_WI:
            begin
                s_req.we    = 1'b1;
                s_req.waddr = i_reg;
                s_req.wdata = s_rdata;
                b_next      = s_rdata;
            end
            rc4kc_pkg::ST_PR_WJ:
            begin
                s_req.we    = 1'b1;
                s_req.waddr = j_reg;
                s_req.wdata = a_reg;
                if (dropping_reg)
                begin
                    drop_left_next = drop_left_reg - rc4kc_pkg::DROP_W'(1);
                end
            end
            rc4kc_pkg::ST_PR_RT:
            begin
                add_x       = a_reg;
                add_y       = b_reg;
                s_req.raddr = add_sum;
            end
            rc4kc_pkg::ST_PR_OUT:
            begin
                // hold the read address so the keystream byte stays put while stalled
                add_x       = a_reg;
                add_y       = b_reg;
                s_req.raddr = add_sum;
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.result_byte = byte_reg ^ s_rdata;
                    rsp_data_next.result_last = last_reg;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rc4kc_pkg::ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            key_count_reg  <= '0;
            drop_count_reg <= rc4kc_pkg::DROP_RESET;
            dropping_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            key_count_reg  <= key_count_next;
            drop_count_reg <= drop_count_next;
            dropping_reg   <= dropping_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        k_reg         <= k_next;
        len_reg       <= len_next;
        drop_left_reg <= drop_left_next;
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ----- hw/rtl/rc4_keystream_cipher_top.sv -----
// RC4 stream cipher with a programmable keystream drop (drop_count, reset 1024).
// Send the key as key requests (password then IV), flagging the final byte; up to
// 256 key bytes are kept and extra bytes are ignored. A key byte is stored as it is
// taken and the block stays ready. The final key byte starts the schedule, during
// which the block is busy: load the identity table, run the 256 mixing steps (read,
// update j, two swap writes), then one keystream step per dropped byte. A data
// request runs one keystream step and the output read and returns its byte XORed
// with the next keystream byte; the next request is taken once that result is
// registered, which waits while the previous result is still held. Each read, swap
// write and output read of the permutation table has a state of its own. A finished
// result waits in the output register without blocking the next request. Encrypt
// and decrypt are the same operation. Write drop_count only while idle.
module rc4_keystream_cipher_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  rc4kc_pkg::req_t                   req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output rc4kc_pkg::rsp_t                   rsp_data,
    input  logic                              drop_count_we,
    input  logic [rc4kc_pkg::DROP_W-1:0]      drop_count
);

    rc4kc_pkg::ram_req_t s_req;
    rc4kc_pkg::ram_req_t k_req;
    logic [7:0]          s_rdata;
    logic [7:0]          k_rdata;

    rc4kc_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp_data      (rsp_data),
        .drop_count_we (drop_count_we),
        .drop_count    (drop_count),
        .s_req         (s_req),
        .s_rdata       (s_rdata),
        .k_req         (k_req),
        .k_rdata       (k_rdata)
    );

    rc4kc_ram u_perm_table (
        .clk   (clk),
        .req   (s_req),
        .rdata (s_rdata)
    );

    rc4kc_ram u_key_store (
        .clk   (clk),
        .req   (k_req),
        .rdata (k_rdata)
    );

endmodule

// ----- hw/rtl/rc4kc_chk.sv -----
module rc4kc_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input rc4kc_pkg::req_t                   req_data,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input rc4kc_pkg::rsp_t                   rsp_data
);

    logic req_fire;

    assign req_fire = req_valid && req_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed or dropped");

    a_key_byte_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_data.req_type == rc4kc_pkg::REQ_KEY && !req_data.last_flag
        |=> req_ready)
        else $error("key byte did not complete in one cycle");

    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_data.req_type == rc4kc_pkg::REQ_KEY && req_data.last_flag
        |=> !req_ready)
        else $error("ready during key schedule");

    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_data.req_type == rc4kc_pkg::REQ_DATA
        |=> !req_ready ##4 !req_ready)
        else $error("ready while a data request is in flight");

endmodule

bind rc4_keystream_cipher_top rc4kc_chk u_chk (.*);

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT     = 4_000_000;
    localparam int unsigned SCHEDULE_CYCLES = 1280;
    localparam int unsigned PHASE_ITEMS     = 320;

    class cipher_tracker;
        logic [7:0]  sbox [256];
        logic [7:0]  key_bytes [256];
        int unsigned key_len;
        logic [7:0]  pos_i;
        logic [7:0]  pos_j;
        logic [11:0] drop;
        rc4kc_pkg::rsp_t expected_q [$];
        int unsigned errors;

        function new();
            foreach (sbox[n])
            begin
                sbox[n] = 8'h00;
                key_bytes[n] = 8'h00;
            end
            key_len = 0;
            pos_i = 8'h00;
            pos_j = 8'h00;
            drop = rc4kc_pkg::DROP_RESET;
            errors = 0;
        endfunction

        function logic [7:0] next_keystream();
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] t;
            pos_i = pos_i + 8'd1;
            a = sbox[pos_i];
            pos_j = pos_j + a;
            b = sbox[pos_j];
            sbox[pos_i] = b;
            sbox[pos_j] = a;
            t = a + b;
            return sbox[t];
        endfunction

        function void schedule_key(int unsigned len);
            logic [7:0]  j;
            logic [7:0]  t;
            int unsigned k;
            for (int n = 0; n < 256; n++)
                sbox[n] = 8'(n);
            j = 8'h00;
            k = 0;
            for (int n = 0; n < 256; n++)
            begin
                j = j + sbox[n] + key_bytes[k];
                t = sbox[n];
                sbox[n] = sbox[j];
                sbox[j] = t;
                k++;
                if (k >= len)
                    k = 0;
            end
            pos_i = 8'h00;
            pos_j = 8'h00;
            repeat (drop)
                void'(next_keystream());
        endfunction

        function void note_request(rc4kc_pkg::req_t r);
            rc4kc_pkg::rsp_t e;
            if (r.req_type == rc4kc_pkg::REQ_KEY)
            begin
                // drop key bytes past the store size
                if (key_len < rc4kc_pkg::MAX_KEY_LEN)
                begin
                    key_bytes[key_len] = r.byte_value;
                    key_len++;
                end
                if (r.last_flag)
                begin
                    schedule_key(key_len);
                    key_len = 0;
                end
            end
            else
            begin
                e.result_byte = r.byte_value ^ next_keystream();
                e.result_last = r.last_flag;
                expected_q.push_back(e);
            end
        endfunction

        function void check_result(rc4kc_pkg::rsp_t got);
            rc4kc_pkg::rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("result_byte: expected none, actual %02h", got.result_byte);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.result_byte !== e.result_byte)
            begin
                $error("result_byte: expected %02h, actual %02h",
                       e.result_byte, got.result_byte);
                errors++;
            end
            if (got.result_last !== e.result_last)
            begin
                $error("result_last: expected %0b, actual %0b",
                       e.result_last, got.result_last);
                errors++;
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    rc4kc_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_ready;
    rc4kc_pkg::rsp_t rsp_data;
    logic          drop_count_we;
    logic [rc4kc_pkg::DROP_W-1:0] drop_count;

    cipher_tracker tracker;
    bit            calm = 1'b0;
    int unsigned   sent_count = 0;
    int unsigned   cycle_count = 0;

    rc4_keystream_cipher_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp_data      (rsp_data),
        .drop_count_we (drop_count_we),
        .drop_count    (drop_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rc4_keystream_cipher_top verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                tracker.note_request(req_data);
            if (rsp_valid && rsp_ready)
                tracker.check_result(rsp_data);
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    function automatic rc4kc_pkg::req_t make_req(logic kind, logic [7:0] value, logic flag);
        rc4kc_pkg::req_t r;
        r.req_type = kind;
        r.byte_value = value;
        r.last_flag = flag;
        return r;
    endfunction

    task automatic send_request(input rc4kc_pkg::req_t r);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 10);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sent_count++;
    endtask

    task automatic send_data();
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'($urandom), 1'($urandom)));
    endtask

    // hold off until every result is back and any key schedule has run out
    task automatic settle_idle();
        req_valid <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (SCHEDULE_CYCLES + 4 * tracker.drop + 64) @(posedge clk);
    endtask

    task automatic set_drop_count(input logic [rc4kc_pkg::DROP_W-1:0] value);
        drop_count_we <= 1'b1;
        drop_count <= value;
        @(posedge clk);
        drop_count_we <= 1'b0;
        tracker.drop = value;
    endtask

    task automatic run_session(input int unsigned key_len, input int unsigned data_len,
                               input bit abandon);
        int unsigned k;
        for (k = 0; k < key_len; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_data();
            send_request(make_req(rc4kc_pkg::REQ_KEY, 8'($urandom),
                                  !abandon && (k == key_len - 1)));
        end
        for (k = 0; k < data_len; k++)
            send_data();
    endtask

    task automatic run_phase(input logic [rc4kc_pkg::DROP_W-1:0] drop_value,
                             input bit long_first);
        int unsigned stop_at;
        int unsigned key_len;
        int unsigned data_len;
        bit          first;
        settle_idle();
        set_drop_count(drop_value);
        stop_at = sent_count + PHASE_ITEMS;
        first = long_first;
        while (sent_count < stop_at)
        begin
            if (first)
                key_len = $urandom_range(250, 300);
            else if ($urandom_range(0, 9) < 2)
                key_len = $urandom_range(17, 64);
            else
                key_len = $urandom_range(1, 16);
            first = 1'b0;
            if (drop_value >= 1024)
                data_len = $urandom_range(20, 80);
            else
                data_len = $urandom_range(0, 40);
            run_session(key_len, data_len, !long_first && $urandom_range(0, 9) == 0);
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_data <= '0;
        rsp_ready <= 1'b0;
        drop_count_we <= 1'b0;
        drop_count <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_req(rc4kc_pkg::REQ_KEY, 8'h00, 1'b0));
        send_request(make_req(rc4kc_pkg::REQ_KEY, 8'hff, 1'b0));
        send_request(make_req(rc4kc_pkg::REQ_KEY, 8'h80, 1'b1));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'h00, 1'b0));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'hff, 1'b1));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'h55, 1'b0));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'haa, 1'b1));
        // single-byte key
        send_request(make_req(rc4kc_pkg::REQ_KEY, 8'hff, 1'b1));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'h01, 1'b1));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'hfe, 1'b0));
        // data while a key is being entered
        send_request(make_req(rc4kc_pkg::REQ_KEY, 8'h7f, 1'b0));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'h3c, 1'b0));
        send_request(make_req(rc4kc_pkg::REQ_KEY, 8'h01, 1'b1));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'h00, 1'b0));
        send_request(make_req(rc4kc_pkg::REQ_DATA, 8'h80, 1'b1));

        run_phase(12'd0, 1'b1);
        run_phase(12'd4095, 1'b0);
        run_phase(12'd1, 1'b1);
        run_phase(12'($urandom_range(100, 1500)), 1'b0);
        run_phase(12'($urandom_range(2, 63)), 1'b0);
        calm = 1'b1;
        run_phase(12'($urandom_range(0, 255)), 1'b0);
        settle_idle();

        if (tracker.expected_q.size() != 0)
        begin
            $error("result_byte: %0d expected results never arrived",
                   tracker.expected_q.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("rc4_keystream_cipher_top verification clean");
        else
            $display("rc4_keystream_cipher_top verification failed");
        $finish;
    end
endmodule
